### hw/rtl/ucd_pkg.sv
// Shared types and constants for the UTF-8 codepoint decoder.
// No dependencies; used by the channel interfaces and the top level.

package ucd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PEND_W = 2;

  // Result queue: room for the two words of an accepted byte plus two already held
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Continuations still owed
  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0] codepoint;
    logic            last_of_run;
    logic            end_of_text;
  } result_t;

endpackage

### hw/rtl/ucd_byte_if.sv
// Valid/ready channel carrying one byte of a UTF-8 string per word.
// Depends on ucd_pkg for field widths.

interface ucd_byte_if;
  logic                          valid;
  logic                          ready;
  logic [ucd_pkg::BYTE_W-1:0]    text_byte;
  logic                          is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

### hw/rtl/ucd_cp_if.sv
// Valid/ready channel carrying one decoded codepoint per word.
// Depends on ucd_pkg for field widths.

interface ucd_cp_if;
  logic                        valid;
  logic                        ready;
  logic [ucd_pkg::CP_W-1:0]    codepoint;
  logic                        last_of_run;
  logic                        end_of_text;

  modport source (output valid, output codepoint, output last_of_run, output end_of_text,
                  input ready);
  modport sink   (input valid, input codepoint, input last_of_run, input end_of_text,
                  output ready);
endinterface

### hw/rtl/utf8_codepoint_decoder_unit.sv
// UTF-8 codepoint decoder: one byte in, zero to two codepoints out.
// The results of a byte are registered into the result queue and driven from its head.
// Throughput: one byte per cycle while the result queue has room; a byte giving two
// codepoints writes both into the four-entry result queue at once.
// Reset (rst, synchronous): closes any open sequence and empties the queue.
// Depends on ucd_pkg, ucd_byte_if and ucd_cp_if.

module utf8_codepoint_decoder_unit (
  input  logic            clk,
  input  logic            rst,
  ucd_byte_if.sink        bytes,
  ucd_cp_if.source        codepoints
);

  // Decoder state
  logic [ucd_pkg::CP_W-1:0]   partial_cp;
  logic [ucd_pkg::PEND_W-1:0] pending;
  logic [ucd_pkg::CP_W-1:0]   partial_cp_next;
  logic [ucd_pkg::PEND_W-1:0] pending_next;

  // Result queue
  ucd_pkg::result_t                queue [ucd_pkg::QUEUE_DEPTH];
  logic [ucd_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ucd_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ucd_pkg::QCNT_W-1:0]      count;

  // Per-byte decode results
  logic                            push;
  logic                            pop;
  logic [1:0]                      n_res;
  ucd_pkg::result_t                res0;
  ucd_pkg::result_t                res1;

  logic [ucd_pkg::BYTE_W-1:0]      b;
  logic                            is_cont;
  logic                            fresh_emit;
  logic [ucd_pkg::CP_W-1:0]        fresh_cp;
  logic [ucd_pkg::PEND_W-1:0]      fresh_pend;
  logic [ucd_pkg::CP_W-1:0]        fresh_part;
  logic [ucd_pkg::CP_W-1:0]        shifted;
  logic [ucd_pkg::PEND_W-1:0]      pend_dec;
  logic [ucd_pkg::CP_W-1:0]        cp0;
  logic [ucd_pkg::CP_W-1:0]        cp1;

  assign push = bytes.valid && bytes.ready;
  assign pop  = codepoints.valid && codepoints.ready;

  // Accept while two free slots remain
  assign bytes.ready = (count < ucd_pkg::QCNT_W'(ucd_pkg::QUEUE_DEPTH - 1));

  // Decode a byte as if no sequence were open
  always_comb begin
    b          = bytes.text_byte;
    fresh_emit = 1'b1;
    fresh_cp   = ucd_pkg::REPLACEMENT_CP;
    fresh_pend = ucd_pkg::PEND_NONE;
    fresh_part = '0;
    if (b[7] == 1'b0) begin
      fresh_cp = ucd_pkg::CP_W'(b);
    end else if (b[7:5] == 3'b110) begin
      fresh_emit = 1'b0;
      fresh_pend = ucd_pkg::PEND_ONE;
      fresh_part = ucd_pkg::CP_W'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      fresh_emit = 1'b0;
      fresh_pend = ucd_pkg::PEND_TWO;
      fresh_part = ucd_pkg::CP_W'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      fresh_emit = 1'b0;
      fresh_pend = ucd_pkg::PEND_THREE;
      fresh_part = ucd_pkg::CP_W'(b[2:0]);
    end
  end

  // Combine with the open sequence and the end-of-string flag
  always_comb begin
    is_cont         = (pending != ucd_pkg::PEND_NONE) && (b[7:6] == 2'b10);
    shifted         = {partial_cp[ucd_pkg::CP_W-7:0], b[5:0]};
    pend_dec        = pending - ucd_pkg::PEND_ONE;
    n_res           = 2'd0;
    cp0             = ucd_pkg::REPLACEMENT_CP;
    cp1             = ucd_pkg::REPLACEMENT_CP;
    pending_next    = pending;
    partial_cp_next = partial_cp;

    if (is_cont) begin
      pending_next = pend_dec;
      if (pend_dec == ucd_pkg::PEND_NONE) begin
        n_res           = 2'd1;
        cp0             = shifted;
        partial_cp_next = '0;
      end else begin
        partial_cp_next = shifted;
      end
    end else begin
      // Interrupted sequence: replacement, then the byte afresh
      if (pending != ucd_pkg::PEND_NONE) begin
        n_res = 2'd1;
      end
      if (fresh_emit) begin
        if (n_res == 2'd0) begin
          cp0 = fresh_cp;
        end else begin
          cp1 = fresh_cp;
        end
        n_res           = n_res + 2'd1;
        pending_next    = ucd_pkg::PEND_NONE;
        partial_cp_next = (pending != ucd_pkg::PEND_NONE) ? '0 : partial_cp;
      end else begin
        pending_next    = fresh_pend;
        partial_cp_next = fresh_part;
      end
    end

    // Truncated at end: append a replacement, then close
    if (bytes.is_last) begin
      if (pending_next != ucd_pkg::PEND_NONE && n_res != 2'd2) begin
        n_res = n_res + 2'd1;
      end
      pending_next    = ucd_pkg::PEND_NONE;
      partial_cp_next = '0;
    end

    res0.codepoint   = cp0;
    res0.last_of_run = (n_res == 2'd1);
    res0.end_of_text = (n_res == 2'd1) && bytes.is_last;
    res1.codepoint   = cp1;
    res1.last_of_run = 1'b1;
    res1.end_of_text = bytes.is_last;
  end

  // Advance decoder state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= ucd_pkg::PEND_NONE;
      partial_cp <= '0;
    end else if (push) begin
      pending    <= pending_next;
      partial_cp <= partial_cp_next;
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    if (push && n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
      if (n_res == 2'd2) begin
        queue[wr_ptr + ucd_pkg::QPTR_W'(1)] <= res1;
      end
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ucd_pkg::QPTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ucd_pkg::QPTR_W'(1);
      end
      count <= count + (push ? ucd_pkg::QCNT_W'(n_res) : '0) - ucd_pkg::QCNT_W'(pop);
    end
  end

  // Drive the head of the queue
  assign codepoints.valid       = (count != '0);
  assign codepoints.codepoint   = queue[rd_ptr].codepoint;
  assign codepoints.last_of_run = queue[rd_ptr].last_of_run;
  assign codepoints.end_of_text = queue[rd_ptr].end_of_text;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ucd_pkg::QCNT_W'(ucd_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_closed_clear: assert property (@(posedge clk) disable iff (rst)
    pending == ucd_pkg::PEND_NONE |-> partial_cp == '0)
    else $error("partial codepoint left with no open sequence");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    push && bytes.is_last |=> pending == ucd_pkg::PEND_NONE)
    else $error("sequence still open after end of string");

  a_eot_ends_run: assert property (@(posedge clk) disable iff (rst)
    codepoints.valid && codepoints.end_of_text |-> codepoints.last_of_run)
    else $error("end of text on a word that does not end its run");
`endif

endmodule

### verif/tb_utf8_codepoint_decoder_unit.sv
// Self-checking bench for utf8_codepoint_decoder_unit: feeds byte strings and checks
// every decoded codepoint word against a predictor that runs inside the bench.
// Depends on ucd_pkg, ucd_byte_if, ucd_cp_if and the decoder RTL.

module tb_utf8_codepoint_decoder_unit;

  localparam int unsigned RUN_LIMIT    = 600000;
  localparam int unsigned RANDOM_BYTES = 1250;
  localparam int unsigned CHUNK_BYTES  = 250;
  localparam int unsigned TAIL_CYCLES  = 8;

  // Predicts the codepoint words of each accepted byte and checks the output against them
  class codepoint_tracker;
    logic [ucd_pkg::CP_W-1:0]   acc_cp;
    logic [ucd_pkg::PEND_W-1:0] owed;
    ucd_pkg::result_t           due_codepoints[$];
    int unsigned                mismatches;

    function new();
      acc_cp     = '0;
      owed       = ucd_pkg::PEND_NONE;
      mismatches = 0;
    endfunction

    function int unsigned waiting();
      return due_codepoints.size();
    endfunction

    // Advance the decode state by one byte and queue the words it gives
    function void take_byte(logic [ucd_pkg::BYTE_W-1:0] b, logic last);
      logic [ucd_pkg::CP_W-1:0] cps [2];
      int                       n;
      ucd_pkg::result_t         w;
      n = 0;
      if (owed != ucd_pkg::PEND_NONE && b[7:6] == 2'b10) begin
        acc_cp = {acc_cp[ucd_pkg::CP_W-7:0], b[5:0]};
        owed   = owed - ucd_pkg::PEND_ONE;
        if (owed == ucd_pkg::PEND_NONE) begin
          cps[n] = acc_cp;
          n++;
          acc_cp = '0;
        end
      end else begin
        // A non-continuation cuts an open sequence short
        if (owed != ucd_pkg::PEND_NONE) begin
          cps[n] = ucd_pkg::REPLACEMENT_CP;
          n++;
          owed   = ucd_pkg::PEND_NONE;
          acc_cp = '0;
        end
        if (b[7] == 1'b0) begin
          cps[n] = ucd_pkg::CP_W'(b);
          n++;
        end else if (b[7:5] == 3'b110) begin
          acc_cp = ucd_pkg::CP_W'(b[4:0]);
          owed   = ucd_pkg::PEND_ONE;
        end else if (b[7:4] == 4'b1110) begin
          acc_cp = ucd_pkg::CP_W'(b[3:0]);
          owed   = ucd_pkg::PEND_TWO;
        end else if (b[7:3] == 5'b11110) begin
          acc_cp = ucd_pkg::CP_W'(b[2:0]);
          owed   = ucd_pkg::PEND_THREE;
        end else begin
          // stray continuation or invalid lead
          cps[n] = ucd_pkg::REPLACEMENT_CP;
          n++;
        end
      end

      // End of string closes whatever is open
      if (last) begin
        if (owed != ucd_pkg::PEND_NONE && n < 2) begin
          cps[n] = ucd_pkg::REPLACEMENT_CP;
          n++;
        end
        owed   = ucd_pkg::PEND_NONE;
        acc_cp = '0;
      end

      for (int i = 0; i < n; i++) begin
        w.codepoint   = cps[i];
        w.last_of_run = (i == n - 1);
        w.end_of_text = last && (i == n - 1);
        due_codepoints.push_back(w);
      end
    endfunction

    // Compare one accepted output word with the oldest prediction
    function void match_codepoint(ucd_pkg::result_t got);
      ucd_pkg::result_t want;
      if (due_codepoints.size() == 0) begin
        $error("unexpected word: codepoint %h last_of_run %b end_of_text %b",
               got.codepoint, got.last_of_run, got.end_of_text);
        mismatches++;
        return;
      end
      want = due_codepoints.pop_front();
      if (got.codepoint !== want.codepoint) begin
        $error("codepoint: expected %h, actual %h", want.codepoint, got.codepoint);
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, actual %b", want.last_of_run, got.last_of_run);
        mismatches++;
      end
      if (got.end_of_text !== want.end_of_text) begin
        $error("end_of_text: expected %b, actual %b", want.end_of_text, got.end_of_text);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             calm;
  int unsigned      cycle_count = 0;
  codepoint_tracker tracker;

  ucd_byte_if byte_ch ();
  ucd_cp_if   cp_ch ();

  utf8_codepoint_decoder_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .bytes      (byte_ch),
    .codepoints (cp_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [ucd_pkg::BYTE_W-1:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.text_byte <= b;
    byte_ch.is_last   <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    tracker.take_byte(b, last);
  endtask

  // Drop valid and wait for every predicted word to come out
  task automatic hold_until_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.waiting() != 0);
  endtask

  // Mostly well-formed sequences with random payload, some truncated, some raw noise
  task automatic send_random(input int unsigned target);
    logic [ucd_pkg::BYTE_W-1:0] seq[$];
    int unsigned                sent;
    int unsigned                kind;
    int unsigned                need;
    int unsigned                keep;
    logic [ucd_pkg::BYTE_W-1:0] lead;
    logic                       last;
    sent = 0;
    while (sent < target) begin
      seq.delete();
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        seq.push_back({1'b0, 7'($urandom)});
      end else if (kind < 88) begin
        need = $urandom_range(1, 3);
        case (need)
          1: lead = {3'b110, 5'($urandom)};
          2: lead = {4'b1110, 4'($urandom)};
          default: lead = {5'b11110, 3'($urandom)};
        endcase
        // broken sequences stop short of their continuations
        keep = (kind < 75) ? need : $urandom_range(0, need - 1);
        seq.push_back(lead);
        for (int i = 0; i < keep; i++) seq.push_back({2'b10, 6'($urandom)});
      end else begin
        seq.push_back(8'($urandom));
      end
      for (int i = 0; i < seq.size(); i++) begin
        if (i == seq.size() - 1) last = ($urandom_range(0, 9) == 0);
        else last = ($urandom_range(0, 59) == 0);
        send_byte(seq[i], last);
        sent++;
      end
    end
  endtask

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: check accepted words, stall ready at random
  initial begin
    ucd_pkg::result_t got;
    int unsigned      stall_left;
    stall_left = 0;
    cp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && cp_ch.valid && cp_ch.ready) begin
        got.codepoint   = cp_ch.codepoint;
        got.last_of_run = cp_ch.last_of_run;
        got.end_of_text = cp_ch.end_of_text;
        tracker.match_codepoint(got);
      end
      if (stall_left > 0) begin
        cp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        cp_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Input side: reset, directed strings, then random strings in chunks
  initial begin
    int unsigned chunk;
    tracker           = new();
    calm              = 1'b0;
    rst               = 1'b1;
    byte_ch.valid     <= 1'b0;
    byte_ch.text_byte <= '0;
    byte_ch.is_last   <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ASCII extremes, the second ending a string
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // stray continuations
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    // two, three and four byte forms
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // largest value a four byte form can carry
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // invalid lead
    send_byte(8'hF8, 1'b0);
    // sequence interrupted by ASCII
    send_byte(8'hE0, 1'b0);
    send_byte(8'h41, 1'b0);
    // sequence interrupted by an invalid lead at end of string
    send_byte(8'hC0, 1'b0);
    send_byte(8'hFF, 1'b1);
    // string ends with a sequence still open
    send_byte(8'hE1, 1'b0);
    send_byte(8'h80, 1'b1);
    hold_until_drained();

    // Random strings; every other chunk runs without idling
    chunk = 0;
    while (chunk * CHUNK_BYTES < RANDOM_BYTES) begin
      calm = chunk[0];
      send_random(CHUNK_BYTES);
      if (chunk[0]) hold_until_drained();
      chunk++;
    end
    calm = 1'b0;

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
